// ===== design/ebmpd_pkg.sv =====
// Shared types and constants for the ext2 block-map path decoder.
`default_nettype none
package ebmpd_pkg;

  localparam int unsigned IdxW    = 32;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned SlotW   = 14;
  localparam int unsigned DepthW  = 2;
  localparam int unsigned StepW   = 2;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  localparam logic [IdxW-1:0] DirectSlots = 32'd12;
  localparam logic [CfgW-1:0] BslReset    = 5'd10;
  localparam logic [CfgW-1:0] BslMin      = 5'd10;
  localparam logic [CfgW-1:0] BslMax      = 5'd16;

  typedef logic [DepthW-1:0] depth_t;
  localparam depth_t DepthDirect = 2'd0;
  localparam depth_t DepthSingle = 2'd1;
  localparam depth_t DepthDouble = 2'd2;
  localparam depth_t DepthTriple = 2'd3;

endpackage
`default_nettype wire

// ===== design/ext2_block_map_path_decoder_core.sv =====
// ext2 block-map path decoder: logical block index to per-level slot indices.
// Throughput: one result per cycle unless m_axis_tready_i stalls the output; a request
// yields 1 to 3 results (its tree depth, one for a direct slot or an overflow), and
// holds the result port until its last result is taken.
// Three register stages (offset, single/double range, triple range and path expander).
// Reset clears all valid bits and sets block_size_log2 to 10.
`default_nettype none
module ext2_block_map_path_decoder_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ebmpd_pkg::CfgW-1:0]    cfg_wdata_i,    // block_size_log2
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [ebmpd_pkg::InDataW-1:0] s_axis_tdata_i, // [31:0] logical_block
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [1:0] tree_depth, [3:2] level_step, [17:4] slot_index, [18] overflow, [23:19] zero
  output logic [ebmpd_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);
  import ebmpd_pkg::*;

  logic [CfgW-1:0] cfg_q;
  logic [CfgW-1:0] lg_clamp;
  logic [ShiftW-1:0] s_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= BslReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    lg_clamp = cfg_q;
    if (cfg_q < BslMin) begin
      lg_clamp = BslMin;
    end else if (cfg_q > BslMax) begin
      lg_clamp = BslMax;
    end
    s_cur = ShiftW'(lg_clamp - 5'd2);
  end

  // stage 1: direct check and offset
  logic              p1_v_q, p1_direct_q;
  logic [IdxW-1:0]   p1_rel_q;
  logic [ShiftW-1:0] p1_s_q;
  // stage 2: single/double range
  logic              p2_v_q, p2_direct_q, p2_lt1_q, p2_lt2_q;
  logic [IdxW-1:0]   p2_rel_q, p2_r1_q;
  logic [ShiftW-1:0] p2_s_q;
  // stage 3: path expander
  logic              ex_v_q, ex_ovf_q;
  depth_t            ex_depth_q;
  logic [StepW-1:0]  ex_k_q;
  logic [IdxW-1:0]   ex_rel_q;
  logic [ShiftW-1:0] ex_s_q;

  logic in_fire, out_fire, out_last, ex_load, p1_ready;

  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign ex_load  = !ex_v_q || (out_fire && out_last);
  assign p1_ready = !p2_v_q || ex_load;
  assign s_axis_tready_o = !p1_v_q || p1_ready;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  // stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      p1_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p1_direct_q <= s_axis_tdata_i < DirectSlots;
      p1_rel_q    <= (s_axis_tdata_i < DirectSlots) ? s_axis_tdata_i
                                                    : s_axis_tdata_i - DirectSlots;
      p1_s_q      <= s_cur;
    end
  end

  // stage 2
  logic [IdxW-1:0] r1_d;
  logic            lt1_d, lt2_d;

  always_comb begin
    lt1_d = (p1_rel_q >> p1_s_q) == '0;
    r1_d  = p1_rel_q - (IdxW'(1) << p1_s_q);
    lt2_d = (r1_d >> {p1_s_q, 1'b0}) == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (p1_ready) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_ready && p1_v_q) begin
      p2_direct_q <= p1_direct_q;
      p2_rel_q    <= p1_rel_q;
      p2_r1_q     <= r1_d;
      p2_lt1_q    <= lt1_d;
      p2_lt2_q    <= lt2_d;
      p2_s_q      <= p1_s_q;
    end
  end

  // stage 3: triple range, select tree
  logic [IdxW-1:0]   r2_d, rel_d;
  logic [5:0]        s3_d;
  logic              lt3_d, ovf_d;
  depth_t            depth_d;

  always_comb begin
    r2_d  = p2_r1_q - (IdxW'(1) << {p2_s_q, 1'b0});
    s3_d  = 6'({p2_s_q, 1'b0}) + 6'(p2_s_q);
    lt3_d = (r2_d >> s3_d) == '0;
    ovf_d = 1'b0;
    if (p2_direct_q) begin
      depth_d = DepthDirect;
      rel_d   = p2_rel_q;
    end else if (p2_lt1_q) begin
      depth_d = DepthSingle;
      rel_d   = p2_rel_q;
    end else if (p2_lt2_q) begin
      depth_d = DepthDouble;
      rel_d   = p2_r1_q;
    end else if (lt3_d) begin
      depth_d = DepthTriple;
      rel_d   = r2_d;
    end else begin
      depth_d = DepthDirect;
      rel_d   = '0;
      ovf_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q <= 1'b0;
      ex_k_q <= '0;
    end else if (ex_load) begin
      ex_v_q <= p2_v_q;
      ex_k_q <= '0;
    end else if (out_fire) begin
      ex_k_q <= ex_k_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_load && p2_v_q) begin
      ex_depth_q <= depth_d;
      ex_ovf_q   <= ovf_d;
      ex_rel_q   <= rel_d;
      ex_s_q     <= p2_s_q;
    end
  end

  // result forming
  logic [StepW-1:0] lvl_rem;
  logic [4:0]       sh;
  logic [IdxW-1:0]  mask, slot_full;
  logic [SlotW-1:0] slot;

  always_comb begin
    lvl_rem = (ex_depth_q == DepthDirect) ? '0 : ex_depth_q - StepW'(1) - ex_k_q;
    case (lvl_rem)
      2'd1:    sh = 5'(ex_s_q);
      2'd2:    sh = {ex_s_q, 1'b0};
      default: sh = '0;
    endcase
    mask      = (IdxW'(1) << ex_s_q) - IdxW'(1);
    slot_full = (ex_rel_q >> sh) & mask;
    slot      = ex_ovf_q ? '0 : slot_full[SlotW-1:0];
    out_last  = ex_ovf_q || (lvl_rem == '0);
  end

  assign m_axis_tvalid_o = ex_v_q;
  assign m_axis_tlast_o  = out_last;
  assign m_axis_tdata_o  = {5'd0, ex_ovf_q, slot, ex_k_q, ex_depth_q};

  // checks
  a_multi_result_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("path results interrupted");

  a_step_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !m_axis_tlast_o |=> m_axis_tdata_o[3:2] == $past(m_axis_tdata_o[3:2]) + 2'd1)
    else $error("level step did not advance");

  a_ovf_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[18] |-> m_axis_tlast_o && ex_k_q == '0)
    else $error("overflow result not single");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> p1_v_q && p2_v_q && ex_v_q)
    else $error("input stalled with pipeline bubble");

endmodule
`default_nettype wire
